[rtl/pma_pkg.sv]
`timescale 1ns / 1ps
package pma_pkg;
  localparam int unsigned COLUMNS_DEF    = 4;
  localparam int unsigned CHANNELS_DEF   = 8;
  localparam int unsigned WINDOWS_DEF    = 64;
  localparam int unsigned SAMPLES_DEF    = 64;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned OUT_W    = 16;

  // configuration register indexes
  localparam logic [1:0] REG_MODULE  = 2'd0;
  localparam logic [1:0] REG_ROW     = 2'd1;
  localparam logic [1:0] REG_WINDOWS = 2'd2;

  // item kinds
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // classified word handed from front to back
  typedef struct packed {
    logic        is_read;
    logic        do_acc;
    logic        addr_ok;
    logic [1:0]  column;
    logic [3:0]  channel;
    logic [8:0]  window;
    logic [6:0]  sample;
    logic [11:0] value;
  } cmd_t;
endpackage

[rtl/pma_front.sv]
`timescale 1ns / 1ps
module pma_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  input  logic             in_kind,
  input  logic [1:0]       in_module_id,
  input  logic [1:0]       in_row_id,
  input  logic [1:0]       in_column_id,
  input  logic [2:0]       in_channel_id,
  input  logic [5:0]       in_window_id,
  input  logic [5:0]       in_sample_index,
  input  logic [11:0]      in_sample_value,
  input  logic [3:0]       lim_columns,
  input  logic [4:0]       lim_channels,
  input  logic [9:0]       lim_windows,
  input  logic [7:0]       lim_samples,
  output pma_pkg::cmd_t    cmd
);
  logic [1:0] sel_module_r;
  logic [1:0] sel_row_r;
  logic [6:0] win_use_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_module_r <= 2'd0;
      sel_row_r    <= 2'd0;
      win_use_r    <= 7'd64;
    end else if (wr_en) begin
      case (reg_idx)
        pma_pkg::REG_MODULE:  sel_module_r <= pwdata[1:0];
        pma_pkg::REG_ROW:     sel_row_r    <= pwdata[1:0];
        pma_pkg::REG_WINDOWS: win_use_r    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      pma_pkg::REG_MODULE:  prdata = {30'd0, sel_module_r};
      pma_pkg::REG_ROW:     prdata = {30'd0, sel_row_r};
      pma_pkg::REG_WINDOWS: prdata = {25'd0, win_use_r};
      default:              prdata = 32'd0;
    endcase
  end

  // classify the incoming word
  logic addr_ok;
  assign addr_ok = ({2'd0, in_column_id} < lim_columns) &&
                   ({2'd0, in_channel_id} < lim_channels) &&
                   ({4'd0, in_window_id} < lim_windows) &&
                   ({2'd0, in_sample_index} < lim_samples);

  always_comb begin
    cmd.is_read = (in_kind == pma_pkg::KIND_READ);
    cmd.addr_ok = addr_ok;
    cmd.do_acc  = (in_kind == pma_pkg::KIND_ACC) && addr_ok &&
                  (in_module_id == sel_module_r) && (in_row_id == sel_row_r) &&
                  ({1'b0, in_window_id} < win_use_r);
    cmd.column  = in_column_id;
    cmd.channel = {1'b0, in_channel_id};
    cmd.window  = {3'd0, in_window_id};
    cmd.sample  = {1'b0, in_sample_index};
    cmd.value   = in_sample_value;
  end
endmodule

[rtl/pma_back.sv]
`timescale 1ns / 1ps
module pma_back #(
  parameter int unsigned COLUMNS    = pma_pkg::COLUMNS_DEF,
  parameter int unsigned CHANNELS   = pma_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOWS    = pma_pkg::WINDOWS_DEF,
  parameter int unsigned SAMPLES    = pma_pkg::SAMPLES_DEF,
  parameter int unsigned COUNT_BITS = pma_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  pma_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output logic [15:0]   res_mean,
  output logic [15:0]   res_hits,
  output logic          res_empty,
  input  logic          res_take
);
  localparam int unsigned CELLS  = COLUMNS * CHANNELS * WINDOWS * SAMPLES;
  localparam int unsigned AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned SUM_W  = COUNT_BITS + pma_pkg::SAMPLE_W;
  localparam int unsigned NUM_W  = SUM_W + 4;
  localparam int unsigned QW     = NUM_W;
  localparam int unsigned DIV_CW = $clog2(NUM_W + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [SUM_W-1:0]      sum_mem [CELLS];
  logic [COUNT_BITS-1:0] cnt_mem [CELLS];

  logic [2:0]            state_r;
  logic [AW:0]           clr_r;
  logic [AW-1:0]         addr_r;
  pma_pkg::cmd_t         c_r;
  logic [SUM_W-1:0]      sum_rd_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [QW-1:0]         quo_r;
  logic [COUNT_BITS:0]   rem_r;
  logic [NUM_W-1:0]      num_r;
  logic [DIV_CW-1:0]     step_r;
  logic [15:0]           hits_r;
  logic                  empty_r;
  logic                  res_vld_r;
  logic [15:0]           res_mean_r;
  logic [15:0]           res_hits_r;
  logic                  res_empty_r;

  // linear cell address
  logic [AW+8:0] lin;
  assign lin = (((AW+9)'(cmd.column) * (AW+9)'(CHANNELS) + (AW+9)'(cmd.channel))
                * (AW+9)'(WINDOWS) + (AW+9)'(cmd.window)) * (AW+9)'(SAMPLES)
                + (AW+9)'(cmd.sample);

  assign cmd_take  = cmd_valid && (state_r == ST_IDLE);
  assign res_valid = res_vld_r;
  assign res_mean  = res_mean_r;
  assign res_hits  = res_hits_r;
  assign res_empty = res_empty_r;

  // restoring divider step
  logic [COUNT_BITS+1:0] trial;
  assign trial = {rem_r, num_r[NUM_W-1]} - {2'b0, cnt_rd_r};

  // memory ports
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [SUM_W-1:0]      mem_ws;
  logic [COUNT_BITS-1:0] mem_wc;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_ws = sum_rd_r + SUM_W'(c_r.value);
    mem_wc = cnt_rd_r + 1'b1;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r[AW-1:0];
      mem_ws = '0;
      mem_wc = '0;
    end else if (state_r == ST_EXEC && c_r.do_acc && cnt_rd_r != CNT_MAX) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_wa] <= mem_ws;
      cnt_mem[mem_wa] <= mem_wc;
    end
    sum_rd_r <= sum_mem[addr_r];
    cnt_rd_r <= cnt_mem[addr_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(CELLS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: if (cmd_valid) begin
          c_r     <= cmd;
          addr_r  <= lin[AW-1:0];
          state_r <= ST_RD;
        end
        ST_RD: state_r <= ST_EXEC;
        ST_EXEC: begin
          if (!c_r.is_read) state_r <= ST_IDLE;
          else if (!c_r.addr_ok || cnt_rd_r == '0) begin
            hits_r  <= '0;
            empty_r <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            num_r   <= {sum_rd_r, 4'b0};
            rem_r   <= '0;
            quo_r   <= '0;
            step_r  <= '0;
            hits_r  <= 16'(cnt_rd_r);
            empty_r <= 1'b0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          num_r <= num_r << 1;
          if (!trial[COUNT_BITS+1]) begin
            rem_r <= trial[COUNT_BITS:0];
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[COUNT_BITS-1:0], num_r[NUM_W-1]};
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == DIV_CW'(NUM_W - 1)) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_vld_r || res_take) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result register, the back end goes on while a word waits to be popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (state_r == ST_OUT && (!res_vld_r || res_take)) begin
      res_vld_r   <= 1'b1;
      res_mean_r  <= empty_r ? 16'd0 : quo_r[15:0];
      res_hits_r  <= hits_r;
      res_empty_r <= empty_r;
    end else if (res_take) begin
      res_vld_r <= 1'b0;
    end
  end
endmodule

[rtl/pma_queue.sv]
`timescale 1ns / 1ps
module pma_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  pma_pkg::cmd_t wr_data,
  output logic          full,
  output logic          rd_valid,
  output pma_pkg::cmd_t rd_data,
  input  logic          rd_en
);
  pma_pkg::cmd_t buf_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) buf_r[wp_r] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

[rtl/pedestal_mean_accumulator_top.sv]
`timescale 1ns / 1ps
// after reset a clearing pass writes every one of the COLUMNS*CHANNELS*WINDOWS*SAMPLES cells,
// one per cycle (131072 cells by default); the queue takes two words, then full stays high
// config registers come out of reset as module 0, row 0 and 64 windows
// accumulate word: address, memory read, update; the back end then takes the next word
// read word: address, memory read, one divider step per numerator bit (COUNT_BITS+16), then
// the result register loads once the old result is popped; no new word is taken meanwhile
module pedestal_mean_accumulator_top #(
  parameter int unsigned COLUMNS    = pma_pkg::COLUMNS_DEF,
  parameter int unsigned CHANNELS   = pma_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOWS    = pma_pkg::WINDOWS_DEF,
  parameter int unsigned SAMPLES    = pma_pkg::SAMPLES_DEF,
  parameter int unsigned COUNT_BITS = pma_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [1:0]  in_module_id,
  input  logic [1:0]  in_row_id,
  input  logic [1:0]  in_column_id,
  input  logic [2:0]  in_channel_id,
  input  logic [5:0]  in_window_id,
  input  logic [5:0]  in_sample_index,
  input  logic [11:0] in_sample_value,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_mean_value,
  output logic [15:0] out_hit_total,
  output logic        out_cell_empty
);
  pma_pkg::cmd_t cmd_in, cmd_q;
  logic          q_full, q_valid, q_take, res_valid;

  assign pready = 1'b1;
  assign full   = q_full;
  assign empty  = !res_valid;

  // front end: config and classification
  pma_front u_front (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .in_kind, .in_module_id, .in_row_id, .in_column_id, .in_channel_id,
    .in_window_id, .in_sample_index, .in_sample_value,
    .lim_columns(4'(COLUMNS)), .lim_channels(5'(CHANNELS)),
    .lim_windows(10'(WINDOWS)), .lim_samples(8'(SAMPLES)),
    .cmd(cmd_in)
  );

  // decoupling queue
  pma_queue u_queue (
    .clk, .rst_n, .wr_en(push && !q_full), .wr_data(cmd_in), .full(q_full),
    .rd_valid(q_valid), .rd_data(cmd_q), .rd_en(q_take)
  );

  // back end: cell memory and divider
  pma_back #(
    .COLUMNS(COLUMNS), .CHANNELS(CHANNELS), .WINDOWS(WINDOWS),
    .SAMPLES(SAMPLES), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd(cmd_q), .cmd_take(q_take),
    .res_valid, .res_mean(out_mean_value), .res_hits(out_hit_total),
    .res_empty(out_cell_empty), .res_take(pop && !empty)
  );
endmodule

[rtl/pma_checker.sv]
`timescale 1ns / 1ps
module pma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [15:0] out_mean_value,
  input logic [15:0] out_hit_total,
  input logic        out_cell_empty,
  input logic        pready
);
  // empty cell reports zero mean and zero hits
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_cell_empty) |-> (out_mean_value == 16'd0 && out_hit_total == 16'd0))
    else $error("empty cell with nonzero fields");
  // nonempty cell has hits
  a_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_cell_empty) |-> (out_hit_total != 16'd0))
    else $error("nonempty cell with zero hits");
  // result holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_mean_value)))
    else $error("result changed before pop");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind pedestal_mean_accumulator_top pma_checker u_chk (
  .clk, .rst_n, .empty, .pop, .out_mean_value, .out_hit_total,
  .out_cell_empty, .pready
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  localparam int unsigned COUNT_TOP  = 16'hFFFF;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;

  // one input word
  typedef struct {
    logic        kind;
    logic [1:0]  module_id;
    logic [1:0]  row_id;
    logic [1:0]  column_id;
    logic [2:0]  channel_id;
    logic [5:0]  window_id;
    logic [5:0]  sample_index;
    logic [11:0] sample_value;
  } sample_word_t;

  // one expected mean word
  typedef struct {
    logic [15:0] mean_value;
    logic [15:0] hit_total;
    logic        cell_empty;
  } mean_word_t;

  // per-cell pedestal model and pending mean reads
  class pedestal_scoreboard;
    logic [27:0] cell_sum [int unsigned];
    logic [15:0] cell_hits [int unsigned];
    logic [1:0]  sel_module;
    logic [1:0]  sel_row;
    logic [6:0]  win_limit;
    mean_word_t  pending_means[$];
    int unsigned mismatches;
    int unsigned reads_checked;
    int unsigned samples_added;

    function new();
      sel_module = 0;
      sel_row = 0;
      win_limit = 7'd64;
      mismatches = 0;
      reads_checked = 0;
      samples_added = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        pma_pkg::REG_MODULE:  sel_module = value[1:0];
        pma_pkg::REG_ROW:     sel_row = value[1:0];
        pma_pkg::REG_WINDOWS: win_limit = value[6:0];
        default: ;
      endcase
    endfunction

    // note an accepted word, queue its mean if it is a read
    function void note_word(sample_word_t w);
      int unsigned idx;
      logic [15:0] hits;
      logic [27:0] sum;
      logic [31:0] scaled;
      mean_word_t m;
      idx = ((int'(w.column_id) * 8 + int'(w.channel_id)) * 64 + int'(w.window_id)) * 64
            + int'(w.sample_index);
      hits = cell_hits.exists(idx) ? cell_hits[idx] : 16'd0;
      sum = cell_sum.exists(idx) ? cell_sum[idx] : 28'd0;
      if (w.kind == pma_pkg::KIND_ACC) begin
        if (w.module_id == sel_module && w.row_id == sel_row &&
            {1'b0, w.window_id} < win_limit && hits < COUNT_TOP) begin
          cell_sum[idx] = sum + w.sample_value;
          cell_hits[idx] = hits + 16'd1;
          samples_added++;
        end
      end else begin
        if (hits == 0) begin
          m.mean_value = 0;
          m.hit_total = 0;
          m.cell_empty = 1'b1;
        end else begin
          scaled = {sum, 4'b0} / hits;
          m.mean_value = scaled[15:0];
          m.hit_total = hits;
          m.cell_empty = 1'b0;
        end
        pending_means.push_back(m);
      end
    endfunction

    // compare a popped mean word with the oldest pending one
    function void check_mean(mean_word_t got);
      mean_word_t exp_m;
      if (pending_means.size() == 0) begin
        $error("mean word with nothing pending");
        mismatches++;
        return;
      end
      exp_m = pending_means.pop_front();
      reads_checked++;
      if (got.mean_value !== exp_m.mean_value) begin
        $error("mean_value expected %0d got %0d", exp_m.mean_value, got.mean_value);
        mismatches++;
      end
      if (got.hit_total !== exp_m.hit_total) begin
        $error("hit_total expected %0d got %0d", exp_m.hit_total, got.hit_total);
        mismatches++;
      end
      if (got.cell_empty !== exp_m.cell_empty) begin
        $error("cell_empty expected %0d got %0d", exp_m.cell_empty, got.cell_empty);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push;
  logic        full;
  logic        in_kind;
  logic [1:0]  in_module_id;
  logic [1:0]  in_row_id;
  logic [1:0]  in_column_id;
  logic [2:0]  in_channel_id;
  logic [5:0]  in_window_id;
  logic [5:0]  in_sample_index;
  logic [11:0] in_sample_value;
  logic        empty;
  logic        pop;
  logic [15:0] out_mean_value;
  logic [15:0] out_hit_total;
  logic        out_cell_empty;

  pedestal_scoreboard sb;
  longint unsigned cycle_count = 0;
  bit pop_enable;

  pedestal_mean_accumulator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .in_kind(in_kind), .in_module_id(in_module_id), .in_row_id(in_row_id),
    .in_column_id(in_column_id), .in_channel_id(in_channel_id),
    .in_window_id(in_window_id), .in_sample_index(in_sample_index),
    .in_sample_value(in_sample_value),
    .empty(empty), .pop(pop),
    .out_mean_value(out_mean_value), .out_hit_total(out_hit_total),
    .out_cell_empty(out_cell_empty)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pedestal_mean_accumulator_top verification failed");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random pop, pop held high while pop_enable is low, check on handshake
  always @(posedge clk) begin
    mean_word_t got;
    if (rst_n && pop && !empty) begin
      got.mean_value = out_mean_value;
      got.hit_total = out_hit_total;
      got.cell_empty = out_cell_empty;
      sb.check_mean(got);
    end
    if (!rst_n) pop <= 1'b0;
    else if (!pop_enable) pop <= 1'b1;
    else pop <= (gap_len() == 0);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // push one word, holding it until accepted
  task automatic send_word(sample_word_t w);
    push <= 1'b1;
    in_kind <= w.kind;
    in_module_id <= w.module_id;
    in_row_id <= w.row_id;
    in_column_id <= w.column_id;
    in_channel_id <= w.channel_id;
    in_window_id <= w.window_id;
    in_sample_index <= w.sample_index;
    in_sample_value <= w.sample_value;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic idle_push(int unsigned n);
    if (n == 0) return;
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait until all reads are back, then let the back end settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sample_word_t make_word(logic kind, logic [1:0] c, logic [2:0] ch,
                                             logic [5:0] win, logic [5:0] s,
                                             logic [11:0] v);
    sample_word_t w;
    w.kind = kind;
    w.module_id = sb.sel_module;
    w.row_id = sb.sel_row;
    w.column_id = c;
    w.channel_id = ch;
    w.window_id = win;
    w.sample_index = s;
    w.sample_value = v;
    return w;
  endfunction

  // random word aimed at a small hot set of cells
  function automatic sample_word_t random_word();
    sample_word_t w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w = make_word(pma_pkg::KIND_ACC, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 3))
                                               : 6'($urandom_range(0, 63)),
                  ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 3))
                                               : 6'($urandom_range(0, 63)),
                  12'($urandom_range(0, 4095)));
    if (r < 25) w.kind = pma_pkg::KIND_READ;
    if (r >= 85) begin
      w.module_id = 2'($urandom_range(0, 3));
      w.row_id = 2'($urandom_range(0, 3));
    end
    if (w.kind == pma_pkg::KIND_READ && $urandom_range(0, 1)) begin
      w.module_id = 2'($urandom_range(0, 3));
      w.row_id = 2'($urandom_range(0, 3));
    end
    return w;
  endfunction

  task automatic random_phase(int unsigned n);
    repeat (n) begin
      send_word(random_word());
      idle_push(gap_len());
    end
  endtask

  initial begin
    sample_word_t w;
    sb = new();
    pop_enable = 1'b1;
    rst_n = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    push = 0;
    in_kind = 0;
    in_module_id = 0;
    in_row_id = 0;
    in_column_id = 0;
    in_channel_id = 0;
    in_window_id = 0;
    in_sample_index = 0;
    in_sample_value = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty read, extremes, repeat accumulation, selection mismatch
    send_word(make_word(pma_pkg::KIND_READ, 0, 0, 0, 0, 0));
    send_word(make_word(pma_pkg::KIND_ACC, 3, 7, 63, 63, 12'hFFF));
    send_word(make_word(pma_pkg::KIND_ACC, 3, 7, 63, 63, 12'hFFF));
    send_word(make_word(pma_pkg::KIND_ACC, 3, 7, 63, 63, 12'h001));
    send_word(make_word(pma_pkg::KIND_READ, 3, 7, 63, 63, 0));
    send_word(make_word(pma_pkg::KIND_ACC, 0, 0, 0, 0, 12'h000));
    send_word(make_word(pma_pkg::KIND_ACC, 0, 0, 0, 0, 12'hA5A));
    send_word(make_word(pma_pkg::KIND_ACC, 0, 0, 0, 0, 12'h5A5));
    w = make_word(pma_pkg::KIND_ACC, 0, 0, 0, 0, 12'hFFF);
    w.module_id = 2'd3;
    send_word(w);
    w.module_id = sb.sel_module;
    w.row_id = 2'd2;
    send_word(w);
    w = make_word(pma_pkg::KIND_READ, 0, 0, 0, 0, 12'hFFF);
    w.module_id = 2'd3;
    w.row_id = 2'd3;
    send_word(w);
    // pause the sender until every read has come back
    drain();

    // window limit, selection changes
    write_reg(pma_pkg::REG_WINDOWS, 32'd1);
    write_reg(pma_pkg::REG_MODULE, 32'd3);
    write_reg(pma_pkg::REG_ROW, 32'd3);
    send_word(make_word(pma_pkg::KIND_ACC, 1, 2, 0, 5, 12'h123));
    send_word(make_word(pma_pkg::KIND_ACC, 1, 2, 1, 5, 12'h456));
    send_word(make_word(pma_pkg::KIND_READ, 1, 2, 0, 5, 0));
    send_word(make_word(pma_pkg::KIND_READ, 1, 2, 1, 5, 0));
    drain();
    write_reg(pma_pkg::REG_WINDOWS, 32'd0);
    send_word(make_word(pma_pkg::KIND_ACC, 2, 3, 0, 0, 12'h777));
    send_word(make_word(pma_pkg::KIND_READ, 2, 3, 0, 0, 0));
    drain();
    write_reg(pma_pkg::REG_WINDOWS, 32'd127);
    send_word(make_word(pma_pkg::KIND_ACC, 2, 3, 63, 0, 12'h777));
    send_word(make_word(pma_pkg::KIND_READ, 2, 3, 63, 0, 0));
    drain();

    // random phases through several settings
    write_reg(pma_pkg::REG_WINDOWS, 32'd64);
    random_phase(500);
    drain();
    write_reg(pma_pkg::REG_MODULE, 32'd1);
    write_reg(pma_pkg::REG_ROW, 32'd2);
    write_reg(pma_pkg::REG_WINDOWS, 32'd3);
    pop_enable = 1'b0;
    random_phase(450);
    pop_enable = 1'b1;
    drain();
    write_reg(pma_pkg::REG_MODULE, 32'd0);
    write_reg(pma_pkg::REG_ROW, 32'd0);
    write_reg(pma_pkg::REG_WINDOWS, 32'd2);
    random_phase(450);
    drain();
    write_reg(pma_pkg::REG_MODULE, 32'd2);
    write_reg(pma_pkg::REG_ROW, 32'd1);
    write_reg(pma_pkg::REG_WINDOWS, 32'd64);
    random_phase(450);
    drain();

    $display("covered %0d samples added, %0d mean reads checked",
             sb.samples_added, sb.reads_checked);
    $display("register sweeps took the window limit through 0, 1, 64 and 127");
    if (sb.mismatches == 0 && sb.pending_means.size() == 0) begin
      $display("pedestal_mean_accumulator_top verification clean");
    end else begin
      $display("pedestal_mean_accumulator_top verification failed");
    end
    $finish;
  end
endmodule

[files.f]
rtl/pma_pkg.sv
rtl/pma_front.sv
rtl/pma_back.sv
rtl/pma_queue.sv
rtl/pedestal_mean_accumulator_top.sv
rtl/pma_checker.sv
tb/sv/tb_top.sv
